// File: rtl/core/bthc_pkg.sv
package bthc_pkg;

  // sequencer phase, also driven out as the phase field
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_BOIL    = 3'd1,
    MODE_DECHLOR = 3'd2,
    MODE_COOL    = 3'd3,
    MODE_WARM    = 3'd4
  } mode_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_SET_TEMP    = 3'd0,
    REG_HYSTERESIS  = 3'd1,
    REG_PLATEAU_SEC = 3'd2,
    REG_DECHLOR_SEC = 3'd3,
    REG_DECHLOR_EN  = 3'd4,
    REG_FAN_EN      = 3'd5,
    REG_TICKS_SEC   = 3'd6
  } reg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned TempW    = 12;

  // tenths of a degree
  localparam logic signed [12:0] DryLimit  = 13'sd700;
  localparam logic        [9:0]  CoolFloor = 10'd500;

  localparam logic [9:0] SetTempRst    = 10'd500;
  localparam logic [7:0] HystRst       = 8'd20;
  localparam logic [7:0] PlateauSecRst = 8'd60;
  localparam logic [7:0] DechlorSecRst = 8'd120;
  localparam logic [7:0] TicksSecRst   = 8'd20;

  typedef struct packed {
    logic [9:0] set_temperature;
    logic [7:0] hysteresis;
    logic [7:0] plateau_seconds;
    logic [7:0] dechlor_seconds;
    logic       dechlor_enable;
    logic       fan_enable;
    logic [7:0] ticks_per_second;
  } cfg_t;

  // control state apart from the adc plateau level
  typedef struct packed {
    logic [7:0] tick_count;
    logic [7:0] second_count;
    mode_e      mode;
    logic       main_heat;
    logic       aux_heat;
    logic       fan_drive;
  } ctrl_t;

endpackage

// File: rtl/core/bthc_step.sv
module bthc_step import bthc_pkg::*; #(
  parameter int unsigned ADC_BITS = 10
) (
  input  cfg_t                  cfg_i,
  input  ctrl_t                 ctrl_i,
  input  logic [ADC_BITS-1:0]   level_i,
  input  logic                  func_i,
  input  logic                  start_boil_i,
  input  logic [ADC_BITS-1:0]   tank_adc_i,
  input  logic [TempW-1:0]      temperature_i,
  output ctrl_t                 ctrl_o,
  output logic [ADC_BITS-1:0]   level_o,
  output logic                  fault_o
);

  logic signed [12:0] temp_s;
  logic signed [12:0] set_s;
  logic signed [12:0] band_lo_s;
  logic signed [12:0] cool_lim_s;
  logic        [9:0]  floor_v;
  logic        [7:0]  tick_inc;
  logic        [7:0]  sec_base;
  logic        [7:0]  sec_inc;
  logic               step_en;
  logic               level_move;
  logic        [ADC_BITS:0] adc_p1;
  logic               above_set;
  logic               below_band;
  logic               still_hot;
  logic               dry;

  assign temp_s     = {temperature_i[TempW-1], temperature_i};
  assign set_s      = signed'({3'b000, cfg_i.set_temperature});
  assign band_lo_s  = set_s - signed'({5'b00000, cfg_i.hysteresis});
  assign floor_v    = (cfg_i.set_temperature < CoolFloor) ? CoolFloor : cfg_i.set_temperature;
  assign cool_lim_s = signed'({3'b000, floor_v}) + signed'({5'b00000, cfg_i.hysteresis});
  assign above_set  = temp_s > set_s;
  assign below_band = temp_s < band_lo_s;
  assign still_hot  = temp_s > cool_lim_s;
  assign dry        = temp_s < DryLimit;

  assign tick_inc = ctrl_i.tick_count + 8'd1;
  assign step_en  = tick_inc >= cfg_i.ticks_per_second;

  // a reading above the level or more than one count below it restarts the plateau
  assign adc_p1     = {1'b0, tank_adc_i} + {{ADC_BITS{1'b0}}, 1'b1};
  assign level_move = (tank_adc_i > level_i) || (adc_p1 < {1'b0, level_i});
  assign sec_base   = (ctrl_i.mode == MODE_BOIL && level_move) ? 8'd0 : ctrl_i.second_count;
  assign sec_inc    = sec_base + 8'd1;

  // keep-warm thermostat
  function automatic logic warm_aux(input logic aux_in, input logic hi, input logic lo);
    logic r;
    r = aux_in;
    if (hi) begin
      r = 1'b0;
    end else if (lo) begin
      r = 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    ctrl_o  = ctrl_i;
    level_o = level_i;
    fault_o = 1'b0;
    if (func_i) begin
      level_o             = '0;
      ctrl_o.tick_count   = 8'd0;
      ctrl_o.second_count = 8'd0;
      if (start_boil_i) begin
        ctrl_o.main_heat = 1'b1;
        ctrl_o.aux_heat  = 1'b1;
        ctrl_o.mode      = MODE_BOIL;
      end else begin
        ctrl_o.main_heat = 1'b0;
        ctrl_o.mode      = MODE_WARM;
      end
    end else if (!step_en) begin
      ctrl_o.tick_count = tick_inc;
    end else begin
      ctrl_o.tick_count = 8'd0;
      case (ctrl_i.mode)
        MODE_BOIL: begin
          if (level_move) begin
            level_o = tank_adc_i;
          end
          ctrl_o.second_count = sec_inc;
          if (sec_inc >= cfg_i.plateau_seconds) begin
            ctrl_o.main_heat = 1'b0;
            if (cfg_i.dechlor_enable && !dry) begin
              ctrl_o.mode         = MODE_DECHLOR;
              ctrl_o.second_count = 8'd0;
            end else begin
              ctrl_o.aux_heat = 1'b0;
              if (dry) begin
                ctrl_o.mode = MODE_IDLE;
                fault_o     = 1'b1;
              end else begin
                // straight into cooling, evaluated this same second
                ctrl_o.mode      = MODE_COOL;
                ctrl_o.fan_drive = cfg_i.fan_enable;
                if (!still_hot) begin
                  ctrl_o.fan_drive = 1'b0;
                  ctrl_o.mode      = MODE_WARM;
                  ctrl_o.aux_heat  = warm_aux(1'b0, above_set, below_band);
                end
              end
            end
          end
        end
        MODE_DECHLOR: begin
          ctrl_o.second_count = sec_inc;
          if (sec_inc >= cfg_i.dechlor_seconds) begin
            ctrl_o.aux_heat  = 1'b0;
            ctrl_o.mode      = MODE_COOL;
            ctrl_o.fan_drive = cfg_i.fan_enable;
            if (!still_hot) begin
              ctrl_o.fan_drive = 1'b0;
              ctrl_o.mode      = MODE_WARM;
              ctrl_o.aux_heat  = warm_aux(1'b0, above_set, below_band);
            end
          end
        end
        MODE_COOL: begin
          ctrl_o.fan_drive = cfg_i.fan_enable;
          if (!still_hot) begin
            ctrl_o.fan_drive = 1'b0;
            ctrl_o.mode      = MODE_WARM;
            ctrl_o.aux_heat  = warm_aux(ctrl_i.aux_heat, above_set, below_band);
          end
        end
        MODE_WARM: begin
          ctrl_o.aux_heat = warm_aux(ctrl_i.aux_heat, above_set, below_band);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/core/boil_tank_heater_controller.sv
// water tank heater sequencer
// input channel (in_valid_i / in_ready_o) carries one word per event: a timer
//   tick (func 0) or a start command (func 1, start_boil picks boil or warm)
// every accepted input word gives exactly one output word on the output
//   channel (out_valid_o / out_ready_i): heater and fan drives, phase and a
//   one-step dry-burn fault flag, all as they stand after that event
// configuration channel (cfg_valid_i / cfg_ready_o) writes one register per
//   word by index; it is always ready and is meant to be used while idle
// an input word is registered, then the step logic updates the state and
//   loads the output register once the output slot is free or drains, and
//   the receiver takes the result from the output register
// throughput: one word per cycle while the receiver is ready, set by the
//   combinational step logic that reads and writes the control state on every evaluated word
// when the receiver stalls, the output register holds its word and the
//   input register holds the next one; input keeps flowing while either
//   has room
// reset clears all control state, the drives and phase to idle, and loads
//   the register defaults
module boil_tank_heater_controller import bthc_pkg::*; #(
  parameter int unsigned ADC_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input words
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                func_i,
  input  logic                start_boil_i,
  input  logic [ADC_BITS-1:0] tank_adc_i,
  input  logic [TempW-1:0]    temperature_i,
  // output words
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                major_heater_o,
  output logic                minor_heater_o,
  output logic                fan_on_o,
  output logic [2:0]          phase_o,
  output logic                dry_burn_fault_o,
  // register writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t                cfg_q;
  ctrl_t               ctrl_q, ctrl_d;
  logic [ADC_BITS-1:0] level_q, level_d;
  logic                fault_d;

  // input register
  logic                in_vld_q;
  logic                func_q;
  logic                start_boil_q;
  logic [ADC_BITS-1:0] tank_adc_q;
  logic [TempW-1:0]    temperature_q;

  // output register
  logic                out_vld_q;
  logic                major_q, minor_q, fan_q, fault_q;
  logic [2:0]          phase_q;

  logic                step_go;

  // the registered word is evaluated whenever the output slot is free or drains
  assign step_go     = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || step_go;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.set_temperature  <= SetTempRst;
      cfg_q.hysteresis       <= HystRst;
      cfg_q.plateau_seconds  <= PlateauSecRst;
      cfg_q.dechlor_seconds  <= DechlorSecRst;
      cfg_q.dechlor_enable   <= 1'b1;
      cfg_q.fan_enable       <= 1'b1;
      cfg_q.ticks_per_second <= TicksSecRst;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_SET_TEMP:    cfg_q.set_temperature  <= cfg_data_i;
        REG_HYSTERESIS:  cfg_q.hysteresis       <= cfg_data_i[7:0];
        REG_PLATEAU_SEC: cfg_q.plateau_seconds  <= cfg_data_i[7:0];
        REG_DECHLOR_SEC: cfg_q.dechlor_seconds  <= cfg_data_i[7:0];
        REG_DECHLOR_EN:  cfg_q.dechlor_enable   <= cfg_data_i[0];
        REG_FAN_EN:      cfg_q.fan_enable       <= cfg_data_i[0];
        REG_TICKS_SEC:   cfg_q.ticks_per_second <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // input stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // input stage payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q        <= func_i;
      start_boil_q  <= start_boil_i;
      tank_adc_q    <= tank_adc_i;
      temperature_q <= temperature_i;
    end
  end

  bthc_step #(
    .ADC_BITS (ADC_BITS)
  ) u_step (
    .cfg_i         (cfg_q),
    .ctrl_i        (ctrl_q),
    .level_i       (level_q),
    .func_i        (func_q),
    .start_boil_i  (start_boil_q),
    .tank_adc_i    (tank_adc_q),
    .temperature_i (temperature_q),
    .ctrl_o        (ctrl_d),
    .level_o       (level_d),
    .fault_o       (fault_d)
  );

  // control state advances once per evaluated word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q.tick_count   <= 8'd0;
      ctrl_q.second_count <= 8'd0;
      ctrl_q.mode         <= MODE_IDLE;
      ctrl_q.main_heat    <= 1'b0;
      ctrl_q.aux_heat     <= 1'b0;
      ctrl_q.fan_drive    <= 1'b0;
      level_q             <= '0;
    end else if (step_go) begin
      ctrl_q  <= ctrl_d;
      level_q <= level_d;
    end
  end

  // output stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || out_ready_i) begin
      out_vld_q <= in_vld_q;
    end
  end

  // output stage payload
  always_ff @(posedge clk_i) begin
    if (step_go) begin
      major_q <= ctrl_d.main_heat;
      minor_q <= ctrl_d.aux_heat;
      fan_q   <= ctrl_d.fan_drive;
      phase_q <= ctrl_d.mode;
      fault_q <= fault_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign major_heater_o   = major_q;
  assign minor_heater_o   = minor_q;
  assign fan_on_o         = fan_q;
  assign phase_o          = phase_q;
  assign dry_burn_fault_o = fault_q;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bthc_pkg::*;

  localparam int unsigned AdcBits    = 10;
  localparam int          CycleLimit = 500_000;

  // one input word and one output word, as the predictor sees them
  typedef struct packed {
    logic                func;
    logic                start_boil;
    logic [AdcBits-1:0]  tank_adc;
    logic signed [11:0]  temperature;
  } heat_word_t;

  typedef struct packed {
    logic       major;
    logic       minor;
    logic       fan;
    logic [2:0] phase;
    logic       fault;
  } drive_word_t;

  logic                clk_i;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic                func_i         = 1'b0;
  logic                start_boil_i   = 1'b0;
  logic [AdcBits-1:0]  tank_adc_i     = '0;
  logic [TempW-1:0]    temperature_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic                major_heater_o;
  logic                minor_heater_o;
  logic                fan_on_o;
  logic [2:0]          phase_o;
  logic                dry_burn_fault_o;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i     = '0;

  boil_tank_heater_controller #(
    .ADC_BITS(AdcBits)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .start_boil_i     (start_boil_i),
    .tank_adc_i       (tank_adc_i),
    .temperature_i    (temperature_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .major_heater_o   (major_heater_o),
    .minor_heater_o   (minor_heater_o),
    .fan_on_o         (fan_on_o),
    .phase_o          (phase_o),
    .dry_burn_fault_o (dry_burn_fault_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // words waiting to be sent, drive words waiting to come out
  heat_word_t  pending_words[$];
  drive_word_t expected_drives[$];
  heat_word_t  cur_word;
  logic        word_taken = 1'b0;

  int items_queued    = 0;
  int results_checked = 0;
  int err_count       = 0;
  int cycle_count     = 0;
  int send_idle_pct   = 23;
  int recv_idle_pct   = 77;

  // shadow of the sequencer: settings and control state
  cfg_t       m_cfg;
  logic [7:0] m_ticks;
  logic [7:0] m_secs;
  logic [9:0] m_level;
  mode_e      m_mode;
  logic       m_main;
  logic       m_aux;
  logic       m_fan;

  // keep-warm thermostat: off above setpoint, on below setpoint less the band
  function automatic void warm_thermostat(int t);
    int d;
    d = t - int'(m_cfg.set_temperature);
    if (d > 0) m_aux = 1'b0;
    else if (d < -int'(m_cfg.hysteresis)) m_aux = 1'b1;
  endfunction

  // fan runs until the water is down to max(setpoint, floor) plus the band
  function automatic void fan_cooldown(int t);
    int lim;
    lim = int'(m_cfg.set_temperature);
    if (lim < int'(CoolFloor)) lim = int'(CoolFloor);
    m_fan = m_cfg.fan_enable;
    if (t > lim + int'(m_cfg.hysteresis)) return;
    m_fan  = 1'b0;
    m_mode = MODE_WARM;
    warm_thermostat(t);
  endfunction

  // advance the shadow by one accepted word and give the drive word it causes
  function automatic drive_word_t advance_heater(heat_word_t w);
    drive_word_t r;
    int          t;
    int          adc;
    logic        fault;
    t     = w.temperature;
    adc   = int'(w.tank_adc);
    fault = 1'b0;
    if (w.func) begin
      // a start restarts the sequence from any phase
      m_level = '0;
      m_ticks = '0;
      m_secs  = '0;
      if (w.start_boil) begin
        m_main = 1'b1;
        m_aux  = 1'b1;
        m_mode = MODE_BOIL;
      end else begin
        m_main = 1'b0;
        m_mode = MODE_WARM;
      end
    end else begin
      m_ticks = m_ticks + 8'd1;
      // prescaler of zero makes every tick a control step
      if (m_ticks >= m_cfg.ticks_per_second) begin
        m_ticks = '0;
        case (m_mode)
          MODE_BOIL: begin
            // a rise, or a drop of more than one count, restarts the plateau
            if (adc > int'(m_level) || adc < int'(m_level) - 1) begin
              m_level = w.tank_adc;
              m_secs  = '0;
            end
            m_secs = m_secs + 8'd1;
            if (m_secs >= m_cfg.plateau_seconds) begin
              m_main = 1'b0;
              if (t < int'(DryLimit)) begin
                // dry burn: heaters off, back to idle, one-step fault
                m_aux  = 1'b0;
                m_mode = MODE_IDLE;
                fault  = 1'b1;
              end else if (m_cfg.dechlor_enable) begin
                m_mode = MODE_DECHLOR;
                m_secs = '0;
              end else begin
                m_aux  = 1'b0;
                m_mode = MODE_COOL;
                fan_cooldown(t);
              end
            end
          end
          MODE_DECHLOR: begin
            m_secs = m_secs + 8'd1;
            if (m_secs >= m_cfg.dechlor_seconds) begin
              m_aux  = 1'b0;
              m_mode = MODE_COOL;
              fan_cooldown(t);
            end
          end
          MODE_COOL: fan_cooldown(t);
          MODE_WARM: warm_thermostat(t);
          default: ;
        endcase
      end
    end
    r.major = m_main;
    r.minor = m_aux;
    r.fan   = m_fan;
    r.phase = m_mode;
    r.fault = fault;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    err_count++;
    $display("tb_top: mismatch on %s at output word %0d: got %0d, want %0d",
             what, results_checked, got, want);
  endtask

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // a range end now and then, otherwise anywhere in the range
  function automatic int pick_edge(int lo, int hi);
    case ($urandom_range(3))
      0:       return lo;
      1:       return hi;
      default: return pick(lo, hi);
    endcase
  endfunction

  function automatic void queue_word(bit f, bit sb, int adc, int temp);
    heat_word_t w;
    w.func        = f;
    w.start_boil  = sb;
    w.tank_adc    = adc[AdcBits-1:0];
    w.temperature = temp[11:0];
    pending_words.push_back(w);
    items_queued++;
  endfunction

  // one control second: filler ticks with random content, then the step tick
  function automatic void queue_second(int adc, int temp);
    int span;
    span = (m_cfg.ticks_per_second == 0) ? 1 : int'(m_cfg.ticks_per_second);
    repeat (span - 1) queue_word(1'b0, $urandom_range(1), pick(0, 1023), pick(-500, 1500));
    queue_word(1'b0, $urandom_range(1), adc, temp);
  endfunction

  // one run of the tank: boil to a plateau, then dry burn, or dechlorinate when
  // enabled, cool and keep warm; sometimes straight to keep-warm, sometimes noise first
  function automatic void queue_tank_cycle();
    int lvl;
    int temp;
    int lim;
    int a;
    int set_t;
    int hy;
    bit dry;
    set_t = m_cfg.set_temperature;
    hy    = m_cfg.hysteresis;
    if ($urandom_range(7) == 0)
      repeat (pick(1, 12))
        queue_word($urandom_range(1), $urandom_range(1), pick(0, 1023), pick(-500, 1500));
    if ($urandom_range(4) != 0) begin
      queue_word(1'b1, 1'b1, pick(0, 1023), pick(-500, 1500));
      lvl = pick(0, 300);
      repeat (pick(0, 4)) begin
        lvl += pick(2, 40);
        if (lvl > 1023) lvl = 1023;
        queue_second(lvl, pick(200, 990));
      end
      dry = ($urandom_range(4) == 0);
      if (dry) temp = ($urandom_range(3) == 0) ? 699 : pick(-500, 698);
      else temp = ($urandom_range(3) == 0) ? 700 : pick(701, 1500);
      // reading holds or sags by one count; now and then it jumps
      repeat (int'(m_cfg.plateau_seconds) + pick(0, 2)) begin
        a = lvl - int'($urandom_range(1));
        if (a < 0) a = 0;
        if (m_cfg.plateau_seconds < 20 && $urandom_range(11) == 0) begin
          a   = pick(0, 1023);
          lvl = a;
        end
        queue_second(a, temp);
      end
      if (dry) begin
        repeat (pick(0, 2)) queue_second(pick(0, 1023), pick(-500, 1500));
        return;
      end
      if (m_cfg.dechlor_enable)
        repeat (int'(m_cfg.dechlor_seconds) + pick(0, 2))
          queue_second(pick(0, 1023), pick(600, 1500));
      // cooling: falling water temperature, sometimes landing on the limit
      lim  = ((set_t > int'(CoolFloor)) ? set_t : int'(CoolFloor)) + hy;
      temp = pick(lim + 1, 1500);
      while (temp > lim - 40) begin
        queue_second(pick(0, 1023), temp);
        temp -= pick(5, 90);
        if (temp > lim && temp < lim + 90 && $urandom_range(1)) temp = lim;
      end
    end else begin
      queue_word(1'b1, 1'b0, pick(0, 1023), pick(-500, 1500));
    end
    // keep-warm around both edges of the band
    repeat (pick(3, 12)) begin
      case ($urandom_range(4))
        0:       temp = set_t;
        1:       temp = set_t - hy;
        2:       temp = set_t - hy - 1;
        3:       temp = set_t + 1;
        default: temp = pick(set_t - hy - 30, set_t + 30);
      endcase
      queue_second(pick(0, 1023), temp);
    end
  endfunction

  task automatic write_reg(input reg_idx_e idx, input int val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[CfgDataW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_SET_TEMP:    m_cfg.set_temperature  = val[9:0];
      REG_HYSTERESIS:  m_cfg.hysteresis       = val[7:0];
      REG_PLATEAU_SEC: m_cfg.plateau_seconds  = val[7:0];
      REG_DECHLOR_SEC: m_cfg.dechlor_seconds  = val[7:0];
      REG_DECHLOR_EN:  m_cfg.dechlor_enable   = val[0];
      REG_FAN_EN:      m_cfg.fan_enable       = val[0];
      REG_TICKS_SEC:   m_cfg.ticks_per_second = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_settings(input int st, input int hy, input int pl, input int dc,
                               input int de, input int fe, input int tp);
    write_reg(REG_SET_TEMP, st);
    write_reg(REG_HYSTERESIS, hy);
    write_reg(REG_PLATEAU_SEC, pl);
    write_reg(REG_DECHLOR_SEC, dc);
    write_reg(REG_DECHLOR_EN, de);
    write_reg(REG_FAN_EN, fe);
    write_reg(REG_TICKS_SEC, tp);
  endtask

  // every queued word sent and its drive word checked
  task automatic wait_drained();
    do @(negedge clk_i); while (results_checked != items_queued);
  endtask

  // sender: next word once the current one is taken, with random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || word_taken)) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_word = pending_words.pop_front();
        in_valid_i    <= 1'b1;
        func_i        <= cur_word.func;
        start_boil_i  <= cur_word.start_boil;
        tank_adc_i    <= cur_word.tank_adc;
        temperature_i <= cur_word.temperature;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    word_taken = 1'b0;
  end

  // receiver stalls
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // output words are checked before the word taken at the same edge is predicted
  always @(posedge clk_i) begin
    drive_word_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_drives.size() == 0) begin
          report_mismatch("output word with nothing pending", 1, 0);
        end else begin
          want = expected_drives.pop_front();
          if (major_heater_o !== want.major)
            report_mismatch("major_heater", major_heater_o, want.major);
          if (minor_heater_o !== want.minor)
            report_mismatch("minor_heater", minor_heater_o, want.minor);
          if (fan_on_o !== want.fan)
            report_mismatch("fan_on", fan_on_o, want.fan);
          if (phase_o !== want.phase)
            report_mismatch("phase", phase_o, want.phase);
          if (dry_burn_fault_o !== want.fault)
            report_mismatch("dry_burn_fault", dry_burn_fault_o, want.fault);
        end
        results_checked++;
      end
      if (in_valid_i && in_ready_o) begin
        expected_drives.push_back(advance_heater(cur_word));
        word_taken = 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    int ph;
    int base;
    m_cfg = '{set_temperature: SetTempRst, hysteresis: HystRst,
              plateau_seconds: PlateauSecRst, dechlor_seconds: DechlorSecRst,
              dechlor_enable: 1'b1, fan_enable: 1'b1, ticks_per_second: TicksSecRst};
    m_ticks = '0;
    m_secs  = '0;
    m_level = '0;
    m_mode  = MODE_IDLE;
    m_main  = 1'b0;
    m_aux   = 1'b0;
    m_fan   = 1'b0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: ticks only count, field extremes, a start into keep-warm
    queue_word(1'b0, 1'b0, 0, 0);
    queue_word(1'b0, 1'b1, 1023, -1);
    queue_word(1'b0, 1'b0, 512, -500);
    queue_word(1'b0, 1'b1, 341, 1500);
    queue_word(1'b1, 1'b0, 1023, 1500);
    wait_drained();

    // zero prescaler and zero durations: every tick steps, phases end at once
    load_settings(1000, 200, 0, 0, 1, 1, 0);
    queue_word(1'b1, 1'b1, 0, 0);
    queue_word(1'b0, 1'b0, 5, 1500);     // plateau at first step, into dechlorination
    queue_word(1'b0, 1'b0, 0, 1500);     // hold over, cooling with fan on
    queue_word(1'b0, 1'b0, 0, 1200);     // exactly on the cooling limit
    queue_word(1'b0, 1'b0, 0, 799);      // just below the band
    queue_word(1'b0, 1'b0, 0, 800);      // on the band edge, no change
    queue_word(1'b0, 1'b0, 0, 1001);     // just above setpoint
    queue_word(1'b1, 1'b1, 0, 0);
    queue_word(1'b0, 1'b0, 1023, 699);   // dry burn one tenth under the limit
    queue_word(1'b0, 1'b0, 0, -500);     // idle ignores steps
    queue_word(1'b1, 1'b0, 0, 0);
    queue_word(1'b0, 1'b0, 0, -500);
    queue_word(1'b1, 1'b1, 0, 0);
    queue_word(1'b1, 1'b0, 0, 0);        // restart mid-boil
    wait_drained();

    // no dechlorination, fan disabled, setpoint and band at zero
    load_settings(0, 0, 0, 0, 0, 0, 1);
    queue_word(1'b1, 1'b1, 0, 0);
    queue_word(1'b0, 1'b0, 0, 700);      // straight to cooling at the dry limit
    queue_word(1'b0, 1'b0, 0, 500);
    queue_word(1'b0, 1'b0, 0, 0);
    queue_word(1'b0, 1'b0, 0, -1);
    queue_word(1'b1, 1'b1, 1023, 0);
    queue_word(1'b0, 1'b0, 1023, 699);
    wait_drained();

    // slowest prescaler: one keep-warm second
    load_settings(600, 0, 1, 1, 1, 1, 255);
    queue_word(1'b1, 1'b0, 0, 0);
    queue_second(pick(0, 1023), 599);
    repeat (3) queue_word(1'b0, $urandom_range(1), pick(0, 1023), pick(-500, 1500));

    for (ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 77;
        recv_idle_pct = 23;
      end else if (ph == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_drained();
      case (ph)
        3:       load_settings(pick(0, 1000), pick(0, 200), 255, pick(1, 5), 0, 1, 1);
        7:       load_settings(pick(0, 1000), pick(0, 200), 1, 255, 1, $urandom_range(1), 1);
        default: load_settings(pick_edge(0, 1000), pick_edge(0, 200), pick(0, 6), pick(0, 5),
                               $urandom_range(1), $urandom_range(1), pick(0, 3));
      endcase
      base = items_queued;
      while (items_queued - base < 45) begin
        queue_tank_cycle();
        // sender holds off until the block has caught up
        if ($urandom_range(5) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (err_count == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
